@@ hdl/nirts_pkg.sv @@
// ----------------------------------------------------------------------------
// nirts_pkg
// shared constants, request codes and command kinds for the nearest-in-radius
// top-k selector
// ----------------------------------------------------------------------------
`default_nettype none

package nirts_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int COORD_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 4;

    localparam int REQ_W    = 2;
    localparam int RADIUS_W = 16;
    localparam int LIMIT_W  = 8;
    localparam int ID_W     = 32;
    localparam int DIST_W   = 35;
    localparam int RSQ_W    = 2 * RADIUS_W;

    localparam logic [REQ_W-1:0] REQ_START = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CAND  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FIN   = 2'd2;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_INS,
        CMD_FIN
    } t_cmd_kind;

    localparam int CMD_W = $bits(t_cmd_kind);

endpackage

`default_nettype wire

@@ hdl/nirts_if.sv @@
// ----------------------------------------------------------------------------
// nirts channel interfaces
// request channel and result channel, valid/ready with payload
// ----------------------------------------------------------------------------
`default_nettype none

interface nirts_req_if #(
    parameter int COORD_BITS = nirts_pkg::COORD_BITS_DEF
);
    logic                                  valid;
    logic                                  ready;
    logic [nirts_pkg::REQ_W-1:0]           req_type;
    logic signed [COORD_BITS-1:0]          pos_x;
    logic signed [COORD_BITS-1:0]          pos_y;
    logic [nirts_pkg::RADIUS_W-1:0]        radius;
    logic [nirts_pkg::LIMIT_W-1:0]         target_limit;
    logic [nirts_pkg::ID_W-1:0]            cand_id;
    logic                                  cand_active;

    modport source (
        output valid, req_type, pos_x, pos_y, radius, target_limit, cand_id, cand_active,
        input  ready
    );
    modport sink (
        input  valid, req_type, pos_x, pos_y, radius, target_limit, cand_id, cand_active,
        output ready
    );
endinterface

interface nirts_res_if;
    logic                          valid;
    logic                          ready;
    logic [nirts_pkg::ID_W-1:0]    out_id;
    logic [nirts_pkg::DIST_W-1:0]  out_dist_sq;
    logic                          found;
    logic                          overflow;
    logic                          last;

    modport source (
        output valid, out_id, out_dist_sq, found, overflow, last,
        input  ready
    );
    modport sink (
        input  valid, out_id, out_dist_sq, found, overflow, last,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/nearest_in_radius_topk_select_top.sv @@
// ----------------------------------------------------------------------------
// nearest_in_radius_topk_select_top
// keeps the nearest active candidates within a radius of a query origin,
// sorted by squared distance with ties to the lower id, and emits them on
// finish
//
//   channel   dir   modport   handshake      carries
//   i_req     in    sink      valid/ready    req_type, pos_x/y, radius,
//                                            target_limit, cand_id, cand_active
//   o_res     out   source    valid/ready    out_id, out_dist_sq, found,
//                                            overflow, last
//
// start and candidate items: one per cycle while the queue has room; two front
// stages (difference, then square), the add and radius check feed the queue,
// then one insertion a cycle in the cell list while it is not emitting
// finish: the list rotates out, one result a cycle through the result register
// while o_res is not stalled; an empty list gives one result with found low
// a four-entry command queue lets the front run on while results stall
// synchronous active-low reset clears the query state; list cells are not reset
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_in_radius_topk_select_top #(
    parameter int LIST_DEPTH = nirts_pkg::LIST_DEPTH_DEF,
    parameter int COORD_BITS = nirts_pkg::COORD_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    nirts_req_if.sink    i_req,
    nirts_res_if.source  o_res
);

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int DW = 2 * COORD_BITS + 1;
    localparam int IW = nirts_pkg::ID_W;
    localparam int KW = nirts_pkg::CMD_W;
    localparam int QW = KW + CW + IW + DW;

    logic                   f_valid;
    logic                   f_ready;
    nirts_pkg::t_cmd_kind   f_kind;
    logic [CW-1:0]          f_lim;
    logic [IW-1:0]          f_id;
    logic [DW-1:0]          f_dist;

    logic                   b_valid;
    logic                   b_ready;
    logic [QW-1:0]          q_wr_data;
    logic [QW-1:0]          q_rd_data;

    nirts_front #(
        .LIST_DEPTH (LIST_DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd_kind  (f_kind),
        .o_cmd_lim   (f_lim),
        .o_cmd_id    (f_id),
        .o_cmd_dist  (f_dist)
    );

    assign q_wr_data = {f_kind, f_lim, f_id, f_dist};

    nirts_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr_data  (q_wr_data),
        .o_rd_valid (b_valid),
        .i_rd_ready (b_ready),
        .o_rd_data  (q_rd_data)
    );

    nirts_back #(
        .LIST_DEPTH (LIST_DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (b_valid),
        .o_cmd_ready (b_ready),
        .i_cmd_kind  (nirts_pkg::t_cmd_kind'(q_rd_data[QW-1 -: KW])),
        .i_cmd_lim   (q_rd_data[IW+DW +: CW]),
        .i_cmd_id    (q_rd_data[DW +: IW]),
        .i_cmd_dist  (q_rd_data[DW-1:0]),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

@@ hdl/nirts_queue.sv @@
// ----------------------------------------------------------------------------
// nirts_queue
// short first-in first-out queue of commands between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module nirts_queue #(
    parameter int WIDTH = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_valid,
    output logic                  o_wr_ready,
    input  wire logic [WIDTH-1:0] i_wr_data,
    output logic                  o_rd_valid,
    input  wire logic             i_rd_ready,
    output logic [WIDTH-1:0]      o_rd_data
);

    localparam int DEPTH = nirts_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [NW-1:0]    r_fill;
    logic             push;
    logic             pop;

    assign o_wr_ready = (r_fill != NW'(DEPTH));
    assign o_rd_valid = (r_fill != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

@@ hdl/nirts_front.sv @@
// ----------------------------------------------------------------------------
// nirts_front
// accepts request items, measures squared distance over two stages, checks the
// radius and hands start, insert and finish commands to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module nirts_front #(
    parameter int LIST_DEPTH = nirts_pkg::LIST_DEPTH_DEF,
    parameter int COORD_BITS = nirts_pkg::COORD_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    nirts_req_if.sink                                i_req,
    output logic                                     o_cmd_valid,
    input  wire logic                                i_cmd_ready,
    output nirts_pkg::t_cmd_kind                     o_cmd_kind,
    output logic [$clog2(LIST_DEPTH+1)-1:0]          o_cmd_lim,
    output logic [nirts_pkg::ID_W-1:0]               o_cmd_id,
    output logic [2*COORD_BITS:0]                    o_cmd_dist
);

    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int SQW  = 2 * COORD_BITS;
    localparam int DW   = SQW + 1;
    localparam int RSQW = nirts_pkg::RSQ_W;
    localparam int CMPW = (DW > RSQW) ? DW : RSQW;

    logic                              en;
    logic                              s1_take;
    nirts_pkg::t_cmd_kind              n_s1_kind;
    logic [COORD_BITS:0]               dx;
    logic [COORD_BITS:0]               dy;
    logic [COORD_BITS-1:0]             ux;
    logic [COORD_BITS-1:0]             uy;
    logic [CW-1:0]                     lim_eff;
    logic [DW-1:0]                     dist_sum;
    logic                              in_range;

    logic [COORD_BITS-1:0]             r_origin_x;
    logic [COORD_BITS-1:0]             r_origin_y;
    logic [RSQW-1:0]                   r_radius_sq;

    logic                              r_s1_valid;
    nirts_pkg::t_cmd_kind              r_s1_kind;
    logic [COORD_BITS-1:0]             r_s1_ux;
    logic [COORD_BITS-1:0]             r_s1_uy;
    logic [nirts_pkg::ID_W-1:0]        r_s1_id;
    logic [CW-1:0]                     r_s1_lim;
    logic [nirts_pkg::RADIUS_W-1:0]    r_s1_radius;

    logic                              r_s2_valid;
    nirts_pkg::t_cmd_kind              r_s2_kind;
    logic [SQW-1:0]                    r_s2_sqx;
    logic [SQW-1:0]                    r_s2_sqy;
    logic [nirts_pkg::ID_W-1:0]        r_s2_id;
    logic [CW-1:0]                     r_s2_lim;
    logic [RSQW-1:0]                   r_s2_rsq;

    always_comb begin
        dx = {i_req.pos_x[COORD_BITS-1], i_req.pos_x} - {r_origin_x[COORD_BITS-1], r_origin_x};
        dy = {i_req.pos_y[COORD_BITS-1], i_req.pos_y} - {r_origin_y[COORD_BITS-1], r_origin_y};
        ux = dx[COORD_BITS] ? COORD_BITS'(~dx + 1'b1) : dx[COORD_BITS-1:0];
        uy = dy[COORD_BITS] ? COORD_BITS'(~dy + 1'b1) : dy[COORD_BITS-1:0];

        // zero or above the list depth selects the full list
        if ((i_req.target_limit == '0) ||
            (i_req.target_limit > nirts_pkg::LIMIT_W'(LIST_DEPTH))) begin
            lim_eff = CW'(LIST_DEPTH);
        end else begin
            lim_eff = CW'(i_req.target_limit);
        end

        s1_take   = 1'b0;
        n_s1_kind = nirts_pkg::CMD_INS;
        case (i_req.req_type)
            nirts_pkg::REQ_START: begin
                s1_take   = 1'b1;
                n_s1_kind = nirts_pkg::CMD_START;
            end
            nirts_pkg::REQ_CAND: begin
                s1_take   = i_req.cand_active;
                n_s1_kind = nirts_pkg::CMD_INS;
            end
            nirts_pkg::REQ_FIN: begin
                s1_take   = 1'b1;
                n_s1_kind = nirts_pkg::CMD_FIN;
            end
            default: begin
                s1_take   = 1'b0;
            end
        endcase

        dist_sum    = DW'(r_s2_sqx) + DW'(r_s2_sqy);
        in_range    = CMPW'(dist_sum) <= CMPW'(r_radius_sq);
        o_cmd_valid = r_s2_valid && ((r_s2_kind != nirts_pkg::CMD_INS) || in_range);
        en          = !o_cmd_valid || i_cmd_ready;
    end

    assign i_req.ready = en;
    assign o_cmd_kind  = r_s2_kind;
    assign o_cmd_lim   = r_s2_lim;
    assign o_cmd_id    = r_s2_id;
    assign o_cmd_dist  = dist_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_radius_sq <= '0;
        end else begin
            if (en) begin
                r_s1_valid <= i_req.valid && s1_take;
                r_s2_valid <= r_s1_valid;
                if (r_s2_valid && (r_s2_kind == nirts_pkg::CMD_START)) begin
                    r_radius_sq <= r_s2_rsq;
                end
                if (i_req.valid && (i_req.req_type == nirts_pkg::REQ_START)) begin
                    r_origin_x <= i_req.pos_x;
                    r_origin_y <= i_req.pos_y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_kind   <= n_s1_kind;
            r_s1_ux     <= ux;
            r_s1_uy     <= uy;
            r_s1_id     <= i_req.cand_id;
            r_s1_lim    <= lim_eff;
            r_s1_radius <= i_req.radius;

            r_s2_kind   <= r_s1_kind;
            r_s2_sqx    <= SQW'(r_s1_ux) * SQW'(r_s1_ux);
            r_s2_sqy    <= SQW'(r_s1_uy) * SQW'(r_s1_uy);
            r_s2_id     <= r_s1_id;
            r_s2_lim    <= r_s1_lim;
            r_s2_rsq    <= RSQW'(r_s1_radius) * RSQW'(r_s1_radius);
        end
    end

endmodule

`default_nettype wire

@@ hdl/nirts_back.sv @@
// ----------------------------------------------------------------------------
// nirts_back
// sorted compare-and-shift cell list, one insertion a cycle while taking commands,
// and the emitter that rotates the list through the result register on finish
// ----------------------------------------------------------------------------
`default_nettype none

module nirts_back #(
    parameter int LIST_DEPTH = nirts_pkg::LIST_DEPTH_DEF,
    parameter int COORD_BITS = nirts_pkg::COORD_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cmd_valid,
    output logic                                     o_cmd_ready,
    input  nirts_pkg::t_cmd_kind                     i_cmd_kind,
    input  wire logic [$clog2(LIST_DEPTH+1)-1:0]     i_cmd_lim,
    input  wire logic [nirts_pkg::ID_W-1:0]          i_cmd_id,
    input  wire logic [2*COORD_BITS:0]               i_cmd_dist,
    nirts_res_if.source                              o_res
);

    localparam int CW    = $clog2(LIST_DEPTH + 1);
    localparam int DW    = 2 * COORD_BITS + 1;
    localparam int IW    = nirts_pkg::ID_W;
    localparam int OUTDW = nirts_pkg::DIST_W;

    typedef enum logic {
        ST_CMD,
        ST_EMIT
    } t_state;

    t_state                 r_state;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_limit;
    logic                   r_dropped;
    logic [CW-1:0]          r_left;
    logic                   r_out_valid;
    logic [IW-1:0]          r_out_id;
    logic [OUTDW-1:0]       r_out_dist;
    logic                   r_out_found;
    logic                   r_out_overflow;
    logic                   r_out_last;

    logic [DW-1:0]          r_dist [LIST_DEPTH];
    logic [IW-1:0]          r_id   [LIST_DEPTH];
    logic [DW-1:0]          n_dist [LIST_DEPTH];
    logic [IW-1:0]          n_id   [LIST_DEPTH];

    logic [LIST_DEPTH-1:0]  lt;
    logic [LIST_DEPTH-1:0]  lt_prev;
    logic [LIST_DEPTH-1:0]  vld;
    logic                   ins;
    logic                   ins_ok;
    logic                   full;
    logic                   out_free;
    logic                   rot;

    always_comb begin
        o_cmd_ready = (r_state == ST_CMD);
        ins         = i_cmd_valid && o_cmd_ready && (i_cmd_kind == nirts_pkg::CMD_INS);
        full        = (r_count >= r_limit);
        out_free    = !r_out_valid || o_res.ready;
        rot         = (r_state == ST_EMIT) && out_free && (r_count != '0);

        // empty cells count as sorting after any new entry
        for (int k = 0; k < LIST_DEPTH; k++) begin
            vld[k] = (CW'(k) < r_count);
            lt[k]  = !vld[k] || (i_cmd_dist < r_dist[k]) ||
                     ((i_cmd_dist == r_dist[k]) && (i_cmd_id < r_id[k]));
        end
        lt_prev = lt << 1;
        ins_ok  = !full || (|(lt & vld));

        for (int k = 0; k < LIST_DEPTH; k++) begin
            n_dist[k] = r_dist[k];
            n_id[k]   = r_id[k];
            if (ins && ins_ok && lt[k]) begin
                if (lt_prev[k]) begin
                    n_dist[k] = r_dist[(k == 0) ? 0 : k - 1];
                    n_id[k]   = r_id[(k == 0) ? 0 : k - 1];
                end else begin
                    n_dist[k] = i_cmd_dist;
                    n_id[k]   = i_cmd_id;
                end
            end else if (rot) begin
                // head moves to the tail so the list is whole again after the run
                if (CW'(k + 1) == r_count) begin
                    n_dist[k] = r_dist[0];
                    n_id[k]   = r_id[0];
                end else begin
                    n_dist[k] = r_dist[(k == LIST_DEPTH - 1) ? 0 : k + 1];
                    n_id[k]   = r_id[(k == LIST_DEPTH - 1) ? 0 : k + 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist <= n_dist;
        r_id   <= n_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CMD;
            r_count     <= '0;
            r_limit     <= CW'(LIST_DEPTH);
            r_dropped   <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.ready && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CMD: begin
                    if (i_cmd_valid) begin
                        case (i_cmd_kind)
                            nirts_pkg::CMD_START: begin
                                r_count   <= '0;
                                r_dropped <= 1'b0;
                                r_limit   <= i_cmd_lim;
                            end
                            nirts_pkg::CMD_INS: begin
                                if (full) begin
                                    r_dropped <= 1'b1;
                                end else begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            nirts_pkg::CMD_FIN: begin
                                r_left  <= r_count;
                                r_state <= ST_EMIT;
                            end
                            default: begin
                                r_state <= ST_CMD;
                            end
                        endcase
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_overflow <= r_dropped;
                        if (r_count == '0) begin
                            r_out_id    <= '0;
                            r_out_dist  <= '0;
                            r_out_found <= 1'b0;
                            r_out_last  <= 1'b1;
                            r_state     <= ST_CMD;
                        end else begin
                            r_out_id    <= r_id[0];
                            r_out_dist  <= OUTDW'(r_dist[0]);
                            r_out_found <= 1'b1;
                            r_out_last  <= (r_left == CW'(1));
                            r_left      <= r_left - 1'b1;
                            if (r_left == CW'(1)) begin
                                r_state <= ST_CMD;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= ST_CMD;
                end
            endcase
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.out_id      = r_out_id;
    assign o_res.out_dist_sq = r_out_dist;
    assign o_res.found       = r_out_found;
    assign o_res.overflow    = r_out_overflow;
    assign o_res.last        = r_out_last;

endmodule

`default_nettype wire
